### rtl/core/gcode_xy_offset_rewriter_assert.svh
// Assertion macros for the G-code XY offset rewriter checker.
// Used by the checker file only; no other dependencies.
`ifndef GCODE_XY_OFFSET_REWRITER_ASSERT_SVH
`define GCODE_XY_OFFSET_REWRITER_ASSERT_SVH

// Check a condition in the same cycle as the trigger.
`define GXO_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check a condition in the cycle after the trigger.
`define GXO_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/gxo_pkg.sv
// Shared constants, character codes and helper functions for the G-code XY offset rewriter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gxo_pkg;

   localparam int GXO_PREFIX_BUF  = 32;
   localparam int GXO_FRAC_DIGITS = 6;
   localparam int GXO_INT_DIGITS  = 10;

   localparam int TAG_LEN      = 9;
   localparam int MAX_G_DIGITS = 5;

   localparam logic [1:0] CSR_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_SHIFT_X = 2'd1;
   localparam logic [1:0] CSR_SHIFT_Y = 2'd2;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_UG    = 8'h47;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UY    = 8'h59;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LY    = 8'h79;

   function automatic logic [79:0] pow10(input int n);
      logic [79:0] p;
      p = 80'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 80'd10;
      end
      return p;
   endfunction

   function automatic logic [7:0] tag_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0: ch = 8'h4d;
         4'd1: ch = 8'h42;
         4'd2: ch = 8'h5f;
         4'd3: ch = 8'h4e;
         4'd4: ch = 8'h41;
         4'd5: ch = 8'h54;
         4'd6: ch = 8'h49;
         4'd7: ch = 8'h56;
         4'd8: ch = 8'h45;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/core/gxo_prefix_ram.sv
// Prefix byte store: one write port, one registered read port.
// Depends on gxo_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module gxo_prefix_ram #(
   parameter int DEPTH = gxo_pkg::GXO_PREFIX_BUF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [7:0]               wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [7:0]                    rdata
);
   import gxo_pkg::*;

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/gcode_xy_offset_rewriter.sv
// G-code XY offset rewriter: byte-stream parser with a shared digit unit and output holding stage.
// Depends on gxo_pkg and gxo_prefix_ram.
//
// One byte is taken at a time; req_stall stays high until every output byte caused by that byte
// has been handed to the output register. A byte that passes straight through is accepted, parsed
// and handed off in that order. A rewritten X/Y value is scaled up to FRAC_DIGITS fraction digits,
// put through a signed add (compare, then sum), then worked through each of the
// max(INT_DIGITS + FRAC_DIGITS, 10) + 1 digit positions: one compare-and-subtract unit extracts
// every digit by repeated subtraction of a power of ten. Held marker prefix bytes are released
// one at a time through the registered read port of the prefix store. A stalled output holds any
// step that hands out a byte.
`timescale 1ns / 1ps
`default_nettype none

module gcode_xy_offset_rewriter #(
   parameter int PREFIX_BUF  = gxo_pkg::GXO_PREFIX_BUF,
   parameter int FRAC_DIGITS = gxo_pkg::GXO_FRAC_DIGITS,
   parameter int INT_DIGITS  = gxo_pkg::GXO_INT_DIGITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic [15:0]      rsp_native_line_count,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);
   import gxo_pkg::*;

   localparam int TOP_POS = (INT_DIGITS + FRAC_DIGITS > 10) ? INT_DIGITS + FRAC_DIGITS : 10;
   localparam int W       = $clog2(pow10(TOP_POS + 1)) + 1;
   localparam int KW      = $clog2(TOP_POS + 1);
   localparam int AW      = $clog2(PREFIX_BUF);
   localparam int PCW     = $clog2(PREFIX_BUF + 1);

   typedef enum logic [15:0] {
      S_IDLE  = 16'd1,
      S_FEED  = 16'd2,
      S_REL   = 16'd4,
      S_RELD  = 16'd8,
      S_PAD   = 16'd16,
      S_CMP   = 16'd32,
      S_SUM   = 16'd64,
      S_AX    = 16'd128,
      S_SG    = 16'd256,
      S_DOT   = 16'd512,
      S_DIG   = 16'd1024,
      S_PT    = 16'd2048,
      S_CHR   = 16'd4096,
      S_FIN   = 16'd8192,
      S_TAIL  = 16'd16384,
      S_FLUSH = 16'd32768
   } state_type;

   typedef enum logic [13:0] {
      PH_LEAD   = 14'd1,
      PH_SEMI   = 14'd2,
      PH_MARK   = 14'd4,
      PH_MSEP   = 14'd8,
      PH_MWS    = 14'd16,
      PH_NATIVE = 14'd32,
      PH_PASS   = 14'd64,
      PH_TLEAD  = 14'd128,
      PH_GNUM   = 14'd256,
      PH_BODY   = 14'd512,
      PH_PAREN  = 14'd1024,
      PH_NSTART = 14'd2048,
      PH_NINT   = 14'd4096,
      PH_NFRAC  = 14'd8192
   } phase_type;

   typedef enum logic [2:0] {
      NM_EMPTY = 3'd1,
      NM_LONG  = 3'd2,
      NM_VALUE = 3'd4
   } mode_type;

   logic [W-1:0] pow_tab [TOP_POS+1];

   for (genvar gi = 0; gi <= TOP_POS; gi++) begin : g_pow
      assign pow_tab[gi] = W'(pow10(gi));
   end

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   mode_type      mode_ff, mode_in;
   logic          en_ff, en_in;
   logic [30:0]   sx_ff, sx_in;
   logic [30:0]   sy_ff, sy_in;
   logic          abs_ff, abs_in;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [PCW-1:0] idx_ff, idx_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [3:0]    fd_ff, fd_in;
   logic [16:0]   cmd_ff, cmd_in;
   logic [15:0]   marker_ff, marker_in;
   logic [7:0]    c_ff, c_in;
   logic          last_ff, last_in;
   logic [7:0]    axis_ff, axis_in;
   logic          neg_ff, neg_in;
   logic          seen_ff, seen_in;
   logic          dot_ff, dot_in;
   logic          ret_end_ff, ret_end_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [KW-1:0] k_ff, k_in;
   logic [3:0]    dig_ff, dig_in;
   logic          started_ff, started_in;
   logic          rneg_ff, rneg_in;
   logic          ge_ff, ge_in;
   logic          pend_v_ff, pend_v_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic [15:0]   pend_cnt_ff, pend_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [15:0]   rsp_cnt_ff, rsp_cnt_in;

   logic          mem_we, mem_re;
   logic [7:0]    mem_rdata;
   logic          emit_req;
   logic [7:0]    emit_chr;
   logic          emit_ok, out_free;
   logic          rel_go, num_go, ls_go, ret_sel;
   logic          is_blank, is_digit, is_axis, room, num_empty;
   logic [W-1:0]  acc10, acc_dig, bw, sum, pw;
   logic [30:0]   raw;
   logic [31:0]   bmag;
   logic          bn, rn, need;
   state_type     nxt, ret_target;

   gxo_prefix_ram #(
      .DEPTH(PREFIX_BUF)
   ) u_prefix (
      .clock (clock),
      .we    (mem_we),
      .waddr (pc_ff[AW-1:0]),
      .wdata (c_ff),
      .re    (mem_re),
      .raddr (idx_ff[AW-1:0]),
      .rdata (mem_rdata)
   );

   assign is_blank  = (c_ff == CH_SP) || (c_ff == CH_TAB);
   assign is_digit  = (c_ff >= CH_ZERO) && (c_ff <= CH_NINE);
   assign is_axis   = (c_ff == CH_UX) || (c_ff == CH_LX) || (c_ff == CH_UY) || (c_ff == CH_LY);
   assign room      = pc_ff < PCW'(PREFIX_BUF);
   assign num_empty = (cnt_ff == 4'd0) && (fd_ff == 4'd0);
   assign acc10     = (acc_ff << 3) + (acc_ff << 1);
   assign acc_dig   = acc10 + W'(c_ff[3:0]);
   assign raw       = ((axis_ff == CH_UX) || (axis_ff == CH_LX)) ? sx_ff : sy_ff;
   assign bn        = raw[30];
   assign bmag      = bn ? (32'h8000_0000 - {1'b0, raw}) : {1'b0, raw};
   assign bw        = W'(bmag);
   assign pw        = pow_tab[k_ff];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_ok   = !pend_v_ff || out_free;
   assign nxt       = last_ff ? S_FIN : S_FLUSH;
   assign ret_target = ret_end_ff ? S_TAIL : S_FEED;
   assign need = (mode_ff == NM_LONG) || started_ff || (dig_ff != 4'd0) ||
                 (k_ff <= KW'(FRAC_DIGITS));

   always_comb begin
      if (neg_ff == bn) begin
         sum = acc_ff + bw;
         rn  = neg_ff;
      end else if (ge_ff) begin
         sum = acc_ff - bw;
         rn  = neg_ff;
      end else begin
         sum = bw - acc_ff;
         rn  = bn;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      en_in        = en_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      abs_in       = abs_ff;
      pc_in        = pc_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      fd_in        = fd_ff;
      cmd_in       = cmd_ff;
      marker_in    = marker_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      axis_in      = axis_ff;
      neg_in       = neg_ff;
      seen_in      = seen_ff;
      dot_in       = dot_ff;
      ret_end_in   = ret_end_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      dig_in       = dig_ff;
      started_in   = started_ff;
      rneg_in      = rneg_ff;
      ge_in        = ge_ff;
      pend_v_in    = pend_v_ff;
      pend_byte_in = pend_byte_ff;
      pend_cnt_in  = pend_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      emit_req     = 1'b0;
      emit_chr     = c_ff;
      rel_go       = 1'b0;
      num_go       = 1'b0;
      ls_go        = 1'b0;
      ret_sel      = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:  en_in = csr_wdata[0];
            CSR_SHIFT_X: sx_in = csr_wdata;
            CSR_SHIFT_Y: sy_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               c_in    = req_in_byte;
               last_in = req_in_last;
               if (en_ff) begin
                  state_in = S_FEED;
               end else begin
                  pend_v_in    = 1'b1;
                  pend_byte_in = req_in_byte;
                  pend_cnt_in  = marker_ff;
                  state_in     = S_FLUSH;
               end
            end
         end
         S_FEED: begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (is_blank && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     state_in = nxt;
                  end else if ((c_ff == CH_SEMI) && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     phase_in = PH_SEMI;
                     state_in = nxt;
                  end else begin
                     phase_in = (c_ff == CH_SEMI) ? PH_PASS : PH_TLEAD;
                     rel_go   = 1'b1;
                  end
               end
               PH_SEMI: begin
                  if (is_blank && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     state_in = nxt;
                  end else if ((c_ff == tag_char(4'd0)) && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     cnt_in   = 4'd1;
                     phase_in = PH_MARK;
                     state_in = nxt;
                  end else begin
                     phase_in = PH_PASS;
                     rel_go   = 1'b1;
                  end
               end
               PH_MARK: begin
                  if ((cnt_ff < 4'(TAG_LEN)) && (c_ff == tag_char(cnt_ff)) && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     cnt_in   = cnt_ff + 4'd1;
                     if (cnt_ff + 4'd1 >= 4'(TAG_LEN)) begin
                        phase_in = PH_MSEP;
                     end
                     state_in = nxt;
                  end else begin
                     phase_in = PH_PASS;
                     rel_go   = 1'b1;
                  end
               end
               PH_MSEP: begin
                  if (is_blank && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     phase_in = PH_MWS;
                     state_in = nxt;
                  end else begin
                     phase_in = PH_PASS;
                     rel_go   = 1'b1;
                  end
               end
               PH_MWS: begin
                  if (is_blank && room) begin
                     mem_we   = 1'b1;
                     pc_in    = pc_ff + PCW'(1);
                     state_in = nxt;
                  end else if ((c_ff == CH_LF) || is_blank) begin
                     phase_in = PH_PASS;
                     rel_go   = 1'b1;
                  end else begin
                     pc_in    = '0;
                     if (marker_ff != 16'hffff) begin
                        marker_in = marker_ff + 16'd1;
                     end
                     phase_in = PH_NATIVE;
                  end
               end
               PH_NATIVE, PH_PASS: begin
                  if (emit_ok) begin
                     emit_req = 1'b1;
                     ls_go    = (c_ff == CH_LF);
                     state_in = nxt;
                  end
               end
               PH_TLEAD: begin
                  if (is_blank) begin
                     if (emit_ok) begin
                        emit_req = 1'b1;
                        state_in = nxt;
                     end
                  end else if ((c_ff == CH_UG) || (c_ff == CH_LG)) begin
                     if (emit_ok) begin
                        emit_req = 1'b1;
                        cmd_in   = '0;
                        cnt_in   = 4'd0;
                        phase_in = PH_GNUM;
                        state_in = nxt;
                     end
                  end else begin
                     phase_in = PH_PASS;
                  end
               end
               PH_GNUM: begin
                  if (is_digit) begin
                     if (emit_ok) begin
                        emit_req = 1'b1;
                        if (cnt_ff >= 4'(MAX_G_DIGITS)) begin
                           phase_in = PH_PASS;
                        end else begin
                           cmd_in = (cmd_ff << 3) + (cmd_ff << 1) + 17'(c_ff[3:0]);
                           cnt_in = cnt_ff + 4'd1;
                        end
                        state_in = nxt;
                     end
                  end else begin
                     phase_in = PH_PASS;
                     if (cnt_ff != 4'd0) begin
                        if (cmd_ff == 17'd90) begin
                           abs_in = 1'b1;
                        end else if (cmd_ff == 17'd91) begin
                           abs_in = 1'b0;
                        end else if (((cmd_ff <= 17'd3) && abs_ff) || (cmd_ff == 17'd92)) begin
                           phase_in = PH_BODY;
                        end
                     end
                  end
               end
               PH_BODY: begin
                  if (is_axis) begin
                     axis_in  = c_ff;
                     neg_in   = 1'b0;
                     seen_in  = 1'b0;
                     acc_in   = '0;
                     fd_in    = 4'd0;
                     cnt_in   = 4'd0;
                     phase_in = PH_NSTART;
                     state_in = nxt;
                  end else if (emit_ok) begin
                     emit_req = 1'b1;
                     if (c_ff == CH_LF) begin
                        ls_go = 1'b1;
                     end else if (c_ff == CH_SEMI) begin
                        phase_in = PH_PASS;
                     end else if (c_ff == CH_LPAR) begin
                        phase_in = PH_PAREN;
                     end
                     state_in = nxt;
                  end
               end
               PH_PAREN: begin
                  if (emit_ok) begin
                     emit_req = 1'b1;
                     if (c_ff == CH_LF) begin
                        ls_go = 1'b1;
                     end else if (c_ff == CH_RPAR) begin
                        phase_in = PH_BODY;
                     end
                     state_in = nxt;
                  end
               end
               PH_NSTART: begin
                  if ((c_ff == CH_PLUS) || (c_ff == CH_MINUS)) begin
                     seen_in  = 1'b1;
                     neg_in   = (c_ff == CH_MINUS);
                     phase_in = PH_NINT;
                     state_in = nxt;
                  end else if (is_digit) begin
                     phase_in = PH_NINT;
                  end else if (c_ff == CH_DOT) begin
                     phase_in = PH_NFRAC;
                     state_in = nxt;
                  end else begin
                     num_go = 1'b1;
                  end
               end
               PH_NINT: begin
                  if (is_digit) begin
                     if (cnt_ff >= 4'(INT_DIGITS)) begin
                        mode_in  = NM_LONG;
                        phase_in = PH_BODY;
                        rem_in   = acc_ff;
                        k_in     = KW'(cnt_ff) - KW'(1);
                        dig_in   = 4'd0;
                        state_in = S_AX;
                     end else begin
                        acc_in   = acc_dig;
                        cnt_in   = cnt_ff + 4'd1;
                        state_in = nxt;
                     end
                  end else if (c_ff == CH_DOT) begin
                     phase_in = PH_NFRAC;
                     state_in = nxt;
                  end else begin
                     num_go = 1'b1;
                  end
               end
               PH_NFRAC: begin
                  if (is_digit) begin
                     if (fd_ff < 4'(FRAC_DIGITS)) begin
                        acc_in = acc_dig;
                        fd_in  = fd_ff + 4'd1;
                     end
                     state_in = nxt;
                  end else begin
                     num_go = 1'b1;
                  end
               end
               default: ls_go = 1'b1;
            endcase
         end
         S_REL: begin
            if (idx_ff == pc_ff) begin
               pc_in    = '0;
               state_in = ret_target;
            end else begin
               mem_re   = 1'b1;
               state_in = S_RELD;
            end
         end
         S_RELD: begin
            if (emit_ok) begin
               emit_req = 1'b1;
               emit_chr = mem_rdata;
               idx_in   = idx_ff + PCW'(1);
               state_in = S_REL;
            end
         end
         S_PAD: begin
            if (fd_ff < 4'(FRAC_DIGITS)) begin
               acc_in = acc10;
               fd_in  = fd_ff + 4'd1;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ge_in    = acc_ff >= bw;
            state_in = S_SUM;
         end
         S_SUM: begin
            rem_in     = sum;
            rneg_in    = rn && (sum != '0);
            k_in       = KW'(TOP_POS);
            dig_in     = 4'd0;
            started_in = 1'b0;
            state_in   = S_AX;
         end
         S_AX: begin
            if (emit_ok) begin
               emit_req = 1'b1;
               emit_chr = axis_ff;
               state_in = S_SG;
            end
         end
         S_SG: begin
            if ((mode_ff == NM_VALUE) ? !rneg_ff : !seen_ff) begin
               state_in = (mode_ff == NM_EMPTY) ? S_DOT : S_DIG;
            end else if (emit_ok) begin
               emit_req = 1'b1;
               emit_chr = ((mode_ff == NM_VALUE) || neg_ff) ? CH_MINUS : CH_PLUS;
               state_in = (mode_ff == NM_EMPTY) ? S_DOT : S_DIG;
            end
         end
         S_DOT: begin
            if (!dot_ff) begin
               state_in = ret_target;
            end else if (emit_ok) begin
               emit_req = 1'b1;
               emit_chr = CH_DOT;
               state_in = ret_target;
            end
         end
         S_DIG: begin
            if (rem_ff >= pw) begin
               rem_in = rem_ff - pw;
               dig_in = dig_ff + 4'd1;
            end else if (!need || emit_ok) begin
               if (need) begin
                  emit_req   = 1'b1;
                  emit_chr   = {4'h3, dig_ff};
                  started_in = 1'b1;
               end
               dig_in = 4'd0;
               if (mode_ff == NM_LONG) begin
                  if (k_ff == '0) begin
                     state_in = S_CHR;
                  end else begin
                     k_in = k_ff - KW'(1);
                  end
               end else if (k_ff > KW'(FRAC_DIGITS)) begin
                  k_in = k_ff - KW'(1);
               end else if (rem_ff == '0) begin
                  state_in = ret_target;
               end else if (k_ff == KW'(FRAC_DIGITS)) begin
                  state_in = S_PT;
               end else begin
                  k_in = k_ff - KW'(1);
               end
            end
         end
         S_PT: begin
            if (emit_ok) begin
               emit_req = 1'b1;
               emit_chr = CH_DOT;
               k_in     = KW'(FRAC_DIGITS - 1);
               state_in = S_DIG;
            end
         end
         S_CHR: begin
            if (emit_ok) begin
               emit_req = 1'b1;
               state_in = nxt;
            end
         end
         S_FIN: begin
            unique case (phase_ff)
               PH_LEAD, PH_SEMI, PH_MARK, PH_MSEP, PH_MWS: begin
                  rel_go  = 1'b1;
                  ret_sel = 1'b1;
               end
               PH_NSTART, PH_NINT, PH_NFRAC: begin
                  num_go  = 1'b1;
                  ret_sel = 1'b1;
               end
               default: state_in = S_TAIL;
            endcase
         end
         S_TAIL: begin
            abs_in    = 1'b1;
            marker_in = '0;
            ls_go     = 1'b1;
            state_in  = S_FLUSH;
         end
         S_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_byte_ff;
               rsp_last_in  = 1'b1;
               rsp_cnt_in   = pend_cnt_ff;
               pend_v_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rel_go) begin
         idx_in     = '0;
         ret_end_in = ret_sel;
         state_in   = S_REL;
      end
      if (num_go) begin
         mode_in    = num_empty ? NM_EMPTY : NM_VALUE;
         dot_in     = (phase_ff == PH_NFRAC);
         phase_in   = PH_BODY;
         ret_end_in = ret_sel;
         state_in   = num_empty ? S_AX : S_PAD;
      end
      if (ls_go) begin
         phase_in = PH_LEAD;
         pc_in    = '0;
         cnt_in   = 4'd0;
         cmd_in   = '0;
      end
      if (emit_req) begin
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pend_byte_ff;
            rsp_last_in  = 1'b0;
            rsp_cnt_in   = pend_cnt_ff;
         end
         pend_v_in    = 1'b1;
         pend_byte_in = emit_chr;
         pend_cnt_in  = marker_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LEAD;
         en_ff        <= 1'b0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         abs_ff       <= 1'b1;
         pc_ff        <= '0;
         cnt_ff       <= 4'd0;
         fd_ff        <= 4'd0;
         cmd_ff       <= '0;
         marker_ff    <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         en_ff        <= en_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         abs_ff       <= abs_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         fd_ff        <= fd_in;
         cmd_ff       <= cmd_in;
         marker_ff    <= marker_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      c_ff         <= c_in;
      last_ff      <= last_in;
      axis_ff      <= axis_in;
      neg_ff       <= neg_in;
      seen_ff      <= seen_in;
      dot_ff       <= dot_in;
      ret_end_ff   <= ret_end_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      k_ff         <= k_in;
      dig_ff       <= dig_in;
      started_ff   <= started_in;
      rneg_ff      <= rneg_in;
      ge_ff        <= ge_in;
      pend_byte_ff <= pend_byte_in;
      pend_cnt_ff  <= pend_cnt_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_byte          = rsp_byte_ff;
   assign rsp_out_last          = rsp_last_ff;
   assign rsp_native_line_count = rsp_cnt_ff;

endmodule

`default_nettype wire

### rtl/core/gxo_checker.sv
// Port-level checker for the G-code XY offset rewriter, attached by bind.
// Depends on gcode_xy_offset_rewriter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "gcode_xy_offset_rewriter_assert.svh"

module gxo_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte
);

   `GXO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte), "stalled item changed")
   `GXO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "not busy after accept")
   `GXO_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "item produced while idle")

endmodule

bind gcode_xy_offset_rewriter gxo_checker u_gxo_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte)
);

`default_nettype wire

### verif/gcode_rewrite_checker.sv
// Checker for the G-code XY offset rewriter: watches the byte channels and the register port,
// predicts every rewritten byte and compares it with what the block hands out.
// Depends on gxo_pkg.
`timescale 1ns / 1ps

module gcode_rewrite_checker
   import gxo_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_out_last,
   input  wire logic [15:0] rsp_native_line_count,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               bytes_in,
   output int               bytes_out,
   output int               native_lines
);

   localparam int              HOLD_DEPTH = 32;
   localparam int              NUM_FRAC   = 6;
   localparam int              NUM_INT    = 10;
   localparam int              CMD_DIGITS = 5;
   localparam int              STEP_CAP   = 33;
   localparam longint unsigned SCALE      = 64'd1000000;
   localparam string           MARKER     = "MB_NATIVE";

   typedef enum logic [3:0] {
      P_START, P_SEMI, P_TAG, P_TAGSEP, P_TAGWS, P_VERBATIM, P_COPY,
      P_CMDLEAD, P_CMDNUM, P_ARGS, P_PAREN, P_NUMSTART, P_NUMINT, P_NUMFRAC
   } line_phase_e;

   typedef struct packed {
      logic [7:0]  b;
      logic        last;
      logic [15:0] cnt;
   } out_rec_t;

   out_rec_t        expected_bytes[$];

   bit              en;
   logic [30:0]     sx, sy;
   bit              abs_mode, neg, sign_seen;
   line_phase_e     phase;
   int unsigned     dcount, fdigits, held_n, cmd, marker_n;
   logic [7:0]      axis;
   longint unsigned iacc, facc;
   logic [7:0]      held[HOLD_DEPTH];
   int              step_n;

   function automatic longint unsigned ten_pow(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   function automatic bit blank(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB;
   endfunction

   function automatic bit digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   task automatic put(input logic [7:0] c);
      if (step_n < STEP_CAP) begin
         expected_bytes.push_back('{c, 1'b0, marker_n[15:0]});
         step_n++;
      end
   endtask

   function automatic bit keep(input logic [7:0] c);
      if (held_n < HOLD_DEPTH) begin
         held[held_n] = c;
         held_n++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic spill();
      for (int i = 0; i < held_n; i++) put(held[i]);
      held_n = 0;
   endtask

   task automatic new_line();
      phase  = P_START;
      held_n = 0;
      dcount = 0;
      cmd    = 0;
   endtask

   task automatic put_shifted();
      longint unsigned ai, af, mag, bi, bf, ri, rf;
      bit              rn, bn;
      logic [30:0]     raw;
      logic [7:0]      dg[$];
      int              len;
      ai  = iacc;
      af  = facc * ten_pow(NUM_FRAC - fdigits);
      raw = (axis == CH_UX || axis == CH_LX) ? sx : sy;
      bn  = raw[30];
      mag = bn ? (64'h80000000 - 64'(raw)) : 64'(raw);
      bi  = mag / SCALE;
      bf  = mag % SCALE;
      if (neg == bn) begin
         ri = ai + bi;
         rf = af + bf;
         if (rf >= SCALE) begin
            rf -= SCALE;
            ri++;
         end
         rn = neg;
      end else if (ai > bi || (ai == bi && af >= bf)) begin
         ri = ai - bi;
         if (af >= bf) rf = af - bf;
         else begin
            rf = af + SCALE - bf;
            ri--;
         end
         rn = neg;
      end else begin
         ri = bi - ai;
         if (bf >= af) rf = bf - af;
         else begin
            rf = bf + SCALE - af;
            ri--;
         end
         rn = bn;
      end
      put(axis);
      if (rn && (ri != 0 || rf != 0)) put(CH_MINUS);
      do begin
         dg.push_front(8'(64'd48 + ri % 10));
         ri = ri / 10;
      end while (ri != 0);
      foreach (dg[i]) put(dg[i]);
      len = NUM_FRAC;
      while (len > 0 && (rf / ten_pow(NUM_FRAC - len)) % 10 == 0) len--;
      if (len > 0) begin
         put(CH_DOT);
         for (int k = 1; k <= len; k++) put(8'(64'd48 + (rf / ten_pow(NUM_FRAC - k)) % 10));
      end
   endtask

   task automatic close_number();
      if (dcount + fdigits == 0) begin
         put(axis);
         if (sign_seen) put(neg ? CH_MINUS : CH_PLUS);
         if (phase == P_NUMFRAC) put(CH_DOT);
      end else begin
         put_shifted();
      end
      phase = P_ARGS;
   endtask

   task automatic close_command();
      phase = P_COPY;
      if (dcount != 0) begin
         if (cmd == 90) abs_mode = 1'b1;
         else if (cmd == 91) abs_mode = 1'b0;
         else if ((cmd <= 3 && abs_mode) || cmd == 92) phase = P_ARGS;
      end
   endtask

   task automatic rewrite_byte(input logic [7:0] c);
      bit done;
      done = 1'b0;
      while (!done) begin
         done = 1'b1;
         case (phase)
            P_START: begin
               if (blank(c) && keep(c)) ;
               else if (c == CH_SEMI && keep(c)) phase = P_SEMI;
               else begin
                  spill();
                  phase = (c == CH_SEMI) ? P_COPY : P_CMDLEAD;
                  done  = 1'b0;
               end
            end
            P_SEMI: begin
               if (blank(c) && keep(c)) ;
               else if (c == MARKER[0] && keep(c)) begin
                  dcount = 1;
                  phase  = P_TAG;
               end else begin
                  spill();
                  phase = P_COPY;
                  done  = 1'b0;
               end
            end
            P_TAG: begin
               if (dcount < MARKER.len() && c == MARKER[dcount] && keep(c)) begin
                  dcount++;
                  if (dcount >= MARKER.len()) phase = P_TAGSEP;
               end else begin
                  spill();
                  phase = P_COPY;
                  done  = 1'b0;
               end
            end
            P_TAGSEP: begin
               if (blank(c) && keep(c)) phase = P_TAGWS;
               else begin
                  spill();
                  phase = P_COPY;
                  done  = 1'b0;
               end
            end
            P_TAGWS: begin
               if (blank(c) && keep(c)) ;
               else if (c == CH_LF || blank(c)) begin
                  spill();
                  phase = P_COPY;
                  done  = 1'b0;
               end else begin
                  held_n = 0;
                  if (marker_n < 16'hffff) marker_n++;
                  phase = P_VERBATIM;
                  done  = 1'b0;
               end
            end
            P_VERBATIM, P_COPY: begin
               put(c);
               if (c == CH_LF) new_line();
            end
            P_CMDLEAD: begin
               if (blank(c)) put(c);
               else if (c == CH_UG || c == CH_LG) begin
                  put(c);
                  cmd    = 0;
                  dcount = 0;
                  phase  = P_CMDNUM;
               end else begin
                  phase = P_COPY;
                  done  = 1'b0;
               end
            end
            P_CMDNUM: begin
               if (digit(c)) begin
                  put(c);
                  if (dcount >= CMD_DIGITS) phase = P_COPY;
                  else begin
                     cmd = cmd * 10 + (c - CH_ZERO);
                     dcount++;
                  end
               end else begin
                  close_command();
                  done = 1'b0;
               end
            end
            P_ARGS: begin
               if (c == CH_UX || c == CH_LX || c == CH_UY || c == CH_LY) begin
                  axis      = c;
                  neg       = 1'b0;
                  sign_seen = 1'b0;
                  iacc      = 0;
                  facc      = 0;
                  fdigits   = 0;
                  dcount    = 0;
                  phase     = P_NUMSTART;
               end else begin
                  put(c);
                  if (c == CH_LF) new_line();
                  else if (c == CH_SEMI) phase = P_COPY;
                  else if (c == CH_LPAR) phase = P_PAREN;
               end
            end
            P_PAREN: begin
               put(c);
               if (c == CH_LF) new_line();
               else if (c == CH_RPAR) phase = P_ARGS;
            end
            P_NUMSTART: begin
               if (c == CH_PLUS || c == CH_MINUS) begin
                  sign_seen = 1'b1;
                  neg       = (c == CH_MINUS);
                  phase     = P_NUMINT;
               end else if (digit(c)) begin
                  phase = P_NUMINT;
                  done  = 1'b0;
               end else if (c == CH_DOT) phase = P_NUMFRAC;
               else begin
                  close_number();
                  done = 1'b0;
               end
            end
            P_NUMINT: begin
               if (digit(c)) begin
                  if (dcount >= NUM_INT) begin
                     put(axis);
                     if (sign_seen) put(neg ? CH_MINUS : CH_PLUS);
                     for (int k = dcount; k > 0; k--)
                        put(8'(64'd48 + (iacc / ten_pow((k - 1) % 13)) % 10));
                     put(c);
                     phase = P_ARGS;
                  end else begin
                     iacc = iacc * 10 + 64'(c - CH_ZERO);
                     dcount++;
                  end
               end else if (c == CH_DOT) phase = P_NUMFRAC;
               else begin
                  close_number();
                  done = 1'b0;
               end
            end
            P_NUMFRAC: begin
               if (digit(c)) begin
                  if (fdigits < NUM_FRAC) begin
                     facc = facc * 10 + 64'(c - CH_ZERO);
                     fdigits++;
                  end
               end else begin
                  close_number();
                  done = 1'b0;
               end
            end
            default: begin
               new_line();
               done = 1'b0;
            end
         endcase
      end
   endtask

   task automatic end_program();
      case (phase)
         P_START, P_SEMI, P_TAG, P_TAGSEP, P_TAGWS: spill();
         P_CMDNUM: close_command();
         P_NUMSTART, P_NUMINT, P_NUMFRAC: close_number();
         default: ;
      endcase
      abs_mode = 1'b1;
      marker_n = 0;
      new_line();
   endtask

   task automatic predict(input logic [7:0] c, input logic last);
      int base;
      base   = expected_bytes.size();
      step_n = 0;
      if (!en) put(c);
      else begin
         rewrite_byte(c);
         if (last) end_program();
      end
      if (expected_bytes.size() > base) expected_bytes[$].last = 1'b1;
   endtask

   always @(posedge clock) begin
      out_rec_t want;
      if (reset) begin
         expected_bytes.delete();
         en           = 1'b0;
         sx           = '0;
         sy           = '0;
         abs_mode     = 1'b1;
         neg          = 1'b0;
         sign_seen    = 1'b0;
         axis         = '0;
         iacc         = 0;
         facc         = 0;
         fdigits      = 0;
         marker_n     = 0;
         new_line();
         fail_count   = 0;
         bytes_in     = 0;
         bytes_out    = 0;
         native_lines = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:  en = csr_wdata[0];
               CSR_SHIFT_X: sx = csr_wdata;
               CSR_SHIFT_Y: sy = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict(req_in_byte, req_in_last);
            bytes_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_out++;
            if (rsp_native_line_count > native_lines) native_lines = rsp_native_line_count;
            if (expected_bytes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected byte %h last %b count %0d", $time,
                           rsp_out_byte, rsp_out_last, rsp_native_line_count);
            end else begin
               want = expected_bytes.pop_front();
               if (want.b !== rsp_out_byte || want.last !== rsp_out_last ||
                   want.cnt !== rsp_native_line_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: byte %h/%h last %b/%b count %0d/%0d (expected/actual)",
                              $time, want.b, rsp_out_byte, want.last, rsp_out_last,
                              want.cnt, rsp_native_line_count);
               end
            end
         end
      end
      pending = expected_bytes.size();
   end

endmodule

### verif/tb_gcode_xy_offset_rewriter.sv
// Top of the G-code XY offset rewriter testbench: clock, reset, register settings and byte
// stimulus with random idling on both channels. Depends on gxo_pkg, the block and
// gcode_rewrite_checker.
`timescale 1ns / 1ps

module tb_gcode_xy_offset_rewriter;
   import gxo_pkg::*;

   localparam int DRAIN = 400;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_in_byte = '0;
   logic        req_in_last = 1'b0;
   logic        rsp_stall   = 1'b0;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = CSR_ENABLE;
   logic [30:0] csr_wdata   = '0;
   logic        req_stall, rsp_valid, rsp_out_last;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_native_line_count;
   int          fail_count, pending, bytes_in, bytes_out, native_lines;
   bit          gaps_on = 1'b1;

   gcode_xy_offset_rewriter DUT (.*);

   gcode_rewrite_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random stalls, quiet stretches, and one long hold-off
   initial begin
      int  cyc, hold;
      bit  quiet;
      cyc   = 0;
      hold  = 0;
      quiet = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == 4000) hold = 600;
         if (cyc % 256 == 0) quiet = ($urandom_range(0, 2) == 0);
         if (hold == 0 && !quiet && $urandom_range(0, 99) == 0) hold = $urandom_range(10, 40);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int g;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], last && i == s.len() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN) @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(input bit en, input int sx, input int sy);
      write_reg(CSR_ENABLE, 31'(en));
      write_reg(CSR_SHIFT_X, 31'(sx));
      write_reg(CSR_SHIFT_Y, 31'(sy));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic string rand_number(input bit allow_long);
      string s;
      int    nd, nf;
      s = "";
      case ($urandom_range(0, 3))
         0: s = "-";
         1: s = "+";
         default: ;
      endcase
      nd = $urandom_range(0, 4);
      if (allow_long && $urandom_range(0, 9) == 0) nd = $urandom_range(10, 12);
      for (int i = 0; i < nd; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      if ($urandom_range(0, 1)) begin
         s  = {s, "."};
         nf = $urandom_range(0, 8);
         for (int i = 0; i < nf; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
      return s;
   endfunction

   function automatic string rand_line();
      string axes[4] = '{"X", "Y", "x", "y"};
      string cmds[10] = '{"G0", "G1", "G2", "g3", "G92", "G90", "G91", "G123456", "M104", "g01"};
      string s;
      int    kind, n;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         s = {($urandom_range(0, 3) == 0) ? " " : "", cmds[$urandom_range(0, 9)]};
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            s = {s, " ", axes[$urandom_range(0, 3)], rand_number(1'b1)};
            if ($urandom_range(0, 7) == 0) s = {s, " (X1.5 y2)"};
         end
         if ($urandom_range(0, 5) == 0) s = {s, " F1200 ; X7 Y8"};
      end else if (kind < 72) begin
         s = {";", ($urandom_range(0, 1) ? " " : ""), "MB_NATIVE",
              ($urandom_range(0, 1) ? " \t" : " "), "G1 X", rand_number(1'b0)};
      end else if (kind < 80) begin
         case ($urandom_range(0, 3))
            0: s = "; MB_NAT X1";
            1: s = ";MB_NATIVEX2";
            2: s = "; MB_NATIVE ";
            default: s = " \t; note Y3";
         endcase
      end else begin
         s = "";
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(0, 255)))};
         if (s.len() == 0) s = "q";
      end
      return {s, "\n"};
   endfunction

   task automatic random_traffic(input int budget);
      int    sent;
      string s;
      sent = 0;
      while (sent < budget) begin
         s = rand_line();
         send_text(s, $urandom_range(0, 7) == 0);
         sent += s.len();
      end
   endtask

   initial begin
      string blanks;
      string directed[$];
      blanks = "";
      for (int i = 0; i < 40; i++) blanks = {blanks, " "};
      directed = '{
         "G90\n", "G1 X10 Y-20.5 F300\n", "g2 x.5 y-.25 (arc X1)\n",
         "G91\nG1 X5 Y5\nG90\n", "G92 X0 Y0\n", "G0 X+ Y- X. Y-.\n",
         "G1 X12345678901 Y1\n", "G1 X1.1234567 Y-0.0000009\n", "G123456 X1\n",
         "; MB_NATIVE G1 X7\n", ";  MB_NATIVE\t \tM117 hi\n", "; MB_NATIV X1\n",
         "; MB_NATIVE\n", {";", blanks, "x\n"}, "  \t; plain X1\n", "M104 S200 X1\n",
         "G1 X9999999999.999999 Y-9999999999.999999\n", "G1 X-1.5 Y2.25\n"};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // passthrough, then rewrite with zero, small and extreme shifts, passthrough again and a random shift
      send_text("G1 X1 Y2\n", 1'b0);
      settle();
      apply_setting(1'b1, 0, 0);
      foreach (directed[i]) send_text(directed[i], 1'b0);
      send_text("G1 X5", 1'b1);
      settle();
      apply_setting(1'b1, 1500000, -2250000);
      foreach (directed[i]) send_text(directed[i], i == 6);
      random_traffic(40);
      settle();
      gaps_on = 1'b0;
      apply_setting(1'b1, 1000000000, -1000000000);
      random_traffic(40);
      settle();
      gaps_on = 1'b1;
      apply_setting(1'b1, -1000000000, 1000000000);
      random_traffic(40);
      send_text("  ;", 1'b0);
      settle();
      apply_setting(1'b0, -1000000000, 1000000000);
      random_traffic(30);
      settle();
      apply_setting(1'b1, $urandom_range(0, 2000000000) - 1000000000,
                    $urandom_range(0, 2000000000) - 1000000000);
      random_traffic(40);
      send_text("G1 X3", 1'b1);

      settle();
      $display("Run: %0d bytes in, %0d bytes out across six register settings,", bytes_in,
               bytes_out);
      $display("     markers unwrapped up to a count of %0d per program.", native_lines);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
